// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be true at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/erbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// erbc_pkg
// shared types, constants and the batch clamp for the refill batch controller
// ----------------------------------------------------------------------------
package erbc_pkg;

  localparam int NUM_CLASSES_DEF = 64;

  localparam int HOLD_W     = 20;
  localparam int TICK_W     = 16;
  localparam int BATCH_W    = 16;
  localparam int AVG_W      = 32;
  localparam int DEMAND_W   = 32;
  localparam int STAMP_W    = 64;
  localparam int CLASS_W    = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 20;
  localparam int TARGET_W   = HOLD_W + TICK_W;
  localparam int EMA_SHIFT  = 2;

  localparam logic [HOLD_W-1:0]  HOLD_RST      = 20'd100;
  localparam logic [TICK_W-1:0]  TICKS_RST     = 16'd1000;
  localparam logic [TICK_W-1:0]  DEFAULT_TICKS = 16'd1000;
  localparam logic [BATCH_W-1:0] FLOOR_RST     = 16'd1;
  localparam logic [BATCH_W-1:0] CEIL_RST      = 16'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOLD  = 4'd0,
    REG_TICKS = 4'd1,
    REG_FLOOR = 4'd2,
    REG_CEIL  = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [AVG_W-1:0]   avg;
    logic [STAMP_W-1:0] stamp;
    logic [BATCH_W-1:0] batch;
  } entry_t;

  localparam entry_t ENTRY_RST = '{avg: '0, stamp: '0, batch: FLOOR_RST};

  // ceiling is applied again last so it wins when floor is above it
  function automatic logic [BATCH_W-1:0] clamp_batch(
    input logic [STAMP_W-1:0] b,
    input logic [BATCH_W-1:0] floor_v,
    input logic [BATCH_W-1:0] ceil_v
  );
    logic [STAMP_W-1:0] v;
    v = b;
    if (v > STAMP_W'(ceil_v)) v = STAMP_W'(ceil_v);
    if (v < STAMP_W'(floor_v)) v = STAMP_W'(floor_v);
    if (v > STAMP_W'(ceil_v)) v = STAMP_W'(ceil_v);
    return v[BATCH_W-1:0];
  endfunction

endpackage

// ===== rtl/erbc_state_mem.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// erbc_state_mem
// per-class state memory, single port, registered read, valid bit per entry
// ----------------------------------------------------------------------------
module erbc_state_mem #(
  parameter int NUM_CLASSES = erbc_pkg::NUM_CLASSES_DEF,
  parameter int CLS_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic                wr_en,
  input  logic [CLS_W-1:0]    addr,
  input  erbc_pkg::entry_t    wr_entry,
  output erbc_pkg::entry_t    rd_entry
);
  import erbc_pkg::*;

  entry_t                 mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] valid_r;
  entry_t                 rd_data_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  // entries never written read as their reset contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[addr];
      end
    end
  end

  assign rd_entry = rd_vld_r ? rd_data_r : ENTRY_RST;

  `ASSERT_NEVER(a_single_port, clk, rst_n, rd_en && wr_en, "read and write in one cycle")

endmodule

// ===== rtl/erbc_div.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// erbc_div
// 64-bit unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module erbc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [erbc_pkg::STAMP_W-1:0]  dividend,
  input  logic [erbc_pkg::STAMP_W-1:0]  divisor,
  output logic                          busy,
  output logic                          done,
  output logic [erbc_pkg::STAMP_W-1:0]  quotient
);
  import erbc_pkg::*;

  localparam int CNT_W = $clog2(STAMP_W);

  logic [STAMP_W-1:0] rem_r, rem_nxt;
  logic [STAMP_W-1:0] quo_r, quo_nxt;
  logic [STAMP_W-1:0] dsr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [STAMP_W:0]   shifted;
  logic [STAMP_W:0]   diff;

  always_comb begin
    shifted = {rem_r, quo_r[STAMP_W-1]};
    diff    = shifted - {1'b0, dsr_r};
    if (!diff[STAMP_W]) begin
      rem_nxt = diff[STAMP_W-1:0];
      quo_nxt = {quo_r[STAMP_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[STAMP_W-1:0];
      quo_nxt = {quo_r[STAMP_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(STAMP_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

  `ASSERT_NEVER(a_start_while_busy, clk, rst_n, start && busy_r, "divider restarted while busy")

endmodule

// ===== rtl/ema_refill_batch_controller_core.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// ema_refill_batch_controller_core
// per-class demand average and refill batch prediction with clamping
// ----------------------------------------------------------------------------
// channel  | handshake                 | payload
// ---------+---------------------------+-----------------------------------------
// input    | start & !busy             | in_op in_size_class in_demand in_timestamp
// result   | out_valid, one cycle      | out_batch
// config   | cfg_valid & cfg_ready     | cfg_index cfg_data
//
// a compute with elapsed time passes through read, the two multiply halves,
// sum, divider start, the restoring divider and write; with no elapsed time
// it goes from read straight to write; busy drops as the result goes out
// an in-range set-stamp request holds busy for one cycle, an out-of-range
// class on a compute answers the next cycle with busy staying low
// rst_n is synchronous; the state memory needs no clearing pass, valid bits
// reset at once; the result cannot be stalled and cfg_ready is always high
// ----------------------------------------------------------------------------
module ema_refill_batch_controller_core #(
  parameter int NUM_CLASSES = erbc_pkg::NUM_CLASSES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_op,
  input  logic [erbc_pkg::CLASS_W-1:0]     in_size_class,
  input  logic [erbc_pkg::DEMAND_W-1:0]    in_demand,
  input  logic [erbc_pkg::STAMP_W-1:0]     in_timestamp,
  output logic                             out_valid,
  output logic [erbc_pkg::BATCH_W-1:0]     out_batch,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [erbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [erbc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import erbc_pkg::*;

  localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int PP_W   = AVG_W + TARGET_W / 2;
  localparam int HALF_W = TARGET_W / 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_DIV_GO,
    ST_DIV,
    ST_WRITE
  } state_t;

  state_t               state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [BATCH_W-1:0]   out_batch_r, out_batch_nxt;
  logic [HOLD_W-1:0]    hold_r;
  logic [TICK_W-1:0]    ticks_r;
  logic [BATCH_W-1:0]   floor_r;
  logic [BATCH_W-1:0]   ceil_r;

  logic                 op_r;
  logic [CLS_W-1:0]     cls_r;
  logic [DEMAND_W-1:0]  demand_r;
  logic [STAMP_W-1:0]   now_r;
  logic [AVG_W-1:0]     avg_r, avg_nxt;
  logic [STAMP_W-1:0]   elapsed_r, elapsed_nxt;
  logic [TARGET_W-1:0]  target_r, target_nxt;
  logic [PP_W-1:0]      pp_lo_r;
  logic [PP_W-1:0]      pp_hi_r;
  logic [STAMP_W-1:0]   num_r;
  logic [BATCH_W-1:0]   batch_r, batch_nxt;

  logic                 accept;
  logic                 in_range;
  logic [AVG_W+1:0]     ema_sum;
  logic [TICK_W-1:0]    ticks_eff;
  logic                 mem_rd;
  logic                 mem_wr;
  logic [CLS_W-1:0]     mem_addr;
  entry_t               mem_wdata;
  entry_t               rd_entry;
  logic                 div_start;
  logic                 div_busy;
  logic                 div_done;
  logic [STAMP_W-1:0]   quotient;

  assign accept   = start && (state_r == ST_IDLE);
  assign in_range = ({1'b0, in_size_class} < (CLASS_W + 1)'(NUM_CLASSES));
  assign busy     = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // new average folds in a quarter of the fresh demand
  assign ema_sum   = ((AVG_W + 2)'(rd_entry.avg) << 1) + (AVG_W + 2)'(rd_entry.avg)
                   + (AVG_W + 2)'(demand_r);
  assign ticks_eff = (ticks_r != '0) ? ticks_r : DEFAULT_TICKS;

  assign mem_rd    = accept && in_range;
  assign mem_wr    = ((state_r == ST_READ) && op_r) || (state_r == ST_WRITE);
  assign mem_addr  = accept ? in_size_class[CLS_W-1:0] : cls_r;
  assign div_start = (state_r == ST_DIV_GO);

  always_comb begin
    mem_wdata = rd_entry;
    if (state_r == ST_WRITE) begin
      mem_wdata.avg   = avg_r;
      mem_wdata.batch = batch_r;
    end
    mem_wdata.stamp = now_r;
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    out_batch_nxt = out_batch_r;
    avg_nxt       = AVG_W'(ema_sum >> EMA_SHIFT);
    target_nxt    = TARGET_W'(hold_r) * TARGET_W'(ticks_eff);
    batch_nxt     = batch_r;
    if ((rd_entry.stamp == '0) || (now_r <= rd_entry.stamp)) begin
      elapsed_nxt = '0;
    end else begin
      elapsed_nxt = now_r - rd_entry.stamp;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_range) begin
            state_nxt = ST_READ;
          end else if (!in_op) begin
            out_valid_nxt = 1'b1;
            out_batch_nxt = floor_r;
          end
        end
      end
      ST_READ: begin
        if (op_r) begin
          state_nxt = ST_IDLE;
        end else if (elapsed_nxt == '0) begin
          batch_nxt = clamp_batch(STAMP_W'(rd_entry.batch), floor_r, ceil_r);
          state_nxt = ST_WRITE;
        end else begin
          state_nxt = ST_MUL_LO;
        end
      end
      ST_MUL_LO: state_nxt = ST_MUL_HI;
      ST_MUL_HI: state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_DIV_GO;
      ST_DIV_GO: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          batch_nxt = clamp_batch(quotient, floor_r, ceil_r);
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        out_valid_nxt = 1'b1;
        out_batch_nxt = batch_r;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      out_batch_r <= '0;
      hold_r      <= HOLD_RST;
      ticks_r     <= TICKS_RST;
      floor_r     <= FLOOR_RST;
      ceil_r      <= CEIL_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_batch_r <= out_batch_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HOLD:  hold_r  <= cfg_data[HOLD_W-1:0];
          REG_TICKS: ticks_r <= cfg_data[TICK_W-1:0];
          REG_FLOOR: floor_r <= cfg_data[BATCH_W-1:0];
          REG_CEIL:  ceil_r  <= cfg_data[BATCH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_op;
      cls_r    <= in_size_class[CLS_W-1:0];
      demand_r <= in_demand;
      now_r    <= in_timestamp;
    end
    if (state_r == ST_READ) begin
      avg_r     <= avg_nxt;
      elapsed_r <= elapsed_nxt;
      target_r  <= target_nxt;
    end
    // 32 x 36 product in two halves; the top bits past 64 wrap away
    if (state_r == ST_MUL_LO) begin
      pp_lo_r <= PP_W'(avg_r) * PP_W'(target_r[HALF_W-1:0]);
    end
    if (state_r == ST_MUL_HI) begin
      pp_hi_r <= PP_W'(avg_r) * PP_W'(target_r[TARGET_W-1:HALF_W]);
    end
    if (state_r == ST_SUM) begin
      num_r <= STAMP_W'(pp_lo_r) + {pp_hi_r[STAMP_W-HALF_W-1:0], {HALF_W{1'b0}}};
    end
    batch_r <= batch_nxt;
  end

  erbc_state_mem #(
    .NUM_CLASSES (NUM_CLASSES),
    .CLS_W       (CLS_W)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (mem_rd),
    .wr_en    (mem_wr),
    .addr     (mem_addr),
    .wr_entry (mem_wdata),
    .rd_entry (rd_entry)
  );

  erbc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_r),
    .divisor  (elapsed_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  assign out_valid = out_valid_r;
  assign out_batch = out_batch_r;

  `ASSERT_PROP(a_accept_busy, clk, rst_n, (accept && in_range) |=> busy, "in-range transfer not busy")
  `ASSERT_PROP(a_div_nonzero, clk, rst_n, div_start |-> (elapsed_r != '0), "divide by zero elapsed")
  `ASSERT_PROP(a_div_runs, clk, rst_n, (state_r == ST_DIV_GO) |=> div_busy, "divider did not start")

endmodule
